[hdl/dlcag_pkg.sv]
// Package for the display-list clear address generator.
// Holds field widths, register indexes and size constants; no dependencies.
`default_nettype none
package dlcag_pkg;

  localparam int unsigned MemoryWordsDefault = 1048576;

  localparam int unsigned AddrW   = 20;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned RemainW = 14;
  localparam int unsigned RunW    = 6;
  localparam int unsigned SkipW   = 5;
  localparam int unsigned BankW   = 4;
  localparam int unsigned StartW  = 10;
  localparam int unsigned SizeW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 6;

  localparam logic [RemainW-1:0] ListBaseWords = 14'd1600;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INITIAL_SKIP = 2'd0,
    CFG_SKIP_RUN     = 2'd1,
    CFG_CLEAR_RUN    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_NEXT  = 1'b1
  } action_t;

endpackage
`default_nettype wire

[hdl/display_list_clear_address_gen.sv]
// Result path: input register, then result register; a stalled output holds the item in the input register.
// Throughput: one item per cycle unless out_ready stalls the output; the clear state updates in a single pass per item.
// Reset: rst_n synchronous active low; clears config and clear-state registers, idles the clear, empties both stages.
// Depends on dlcag_pkg.
`default_nettype none
module display_list_clear_address_gen #(
  parameter int unsigned MEMORY_WORDS = dlcag_pkg::MemoryWordsDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_action,
  input  wire logic [dlcag_pkg::BankW-1:0]   in_list_bank,
  input  wire logic [dlcag_pkg::StartW-1:0]  in_list_start,
  input  wire logic [dlcag_pkg::SizeW-1:0]   in_size_select,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [dlcag_pkg::AddrW-1:0]        out_word_address,
  output logic                               out_word_valid,
  output logic                               out_last_word,
  output logic                               out_busy_res,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dlcag_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [dlcag_pkg::CfgDatW-1:0] cfg_data
);

  localparam logic [dlcag_pkg::AddrW-1:0] AddrMask = dlcag_pkg::AddrW'(MEMORY_WORDS - 1);

  logic [dlcag_pkg::SkipW-1:0]   initial_skip_r;
  logic [dlcag_pkg::SkipW-1:0]   skip_run_r;
  logic [dlcag_pkg::RunW-1:0]    clear_run_r;

  logic                          s1_valid_r;
  logic                          s1_action_r;
  logic [dlcag_pkg::BankW-1:0]   s1_bank_r;
  logic [dlcag_pkg::StartW-1:0]  s1_start_r;
  logic [dlcag_pkg::SizeW-1:0]   s1_size_r;

  logic [dlcag_pkg::BankW-1:0]   bank_base_r, bank_base_nxt;
  logic [dlcag_pkg::OffsetW-1:0] word_offset_r, word_offset_nxt;
  logic [dlcag_pkg::RemainW-1:0] words_remaining_r, words_remaining_nxt;
  logic [dlcag_pkg::RunW-1:0]    run_position_r, run_position_nxt;
  logic                          clear_active_r, clear_active_nxt;

  logic                          out_valid_r;
  logic [dlcag_pkg::AddrW-1:0]   addr_r, addr_nxt;
  logic                          wvalid_r, wvalid_nxt;
  logic                          last_r, last_nxt;

  logic                          s2_advance;
  logic                          s1_advance;
  logic                          s1_fire;

  logic [dlcag_pkg::OffsetW-1:0] off_inc;
  logic [dlcag_pkg::RemainW-1:0] rem_dec;
  logic [dlcag_pkg::RunW-1:0]    pos_inc;

  assign s2_advance = !out_valid_r || out_ready;
  assign s1_advance = !s1_valid_r || s2_advance;
  assign s1_fire    = s1_valid_r && s2_advance;
  assign in_ready   = s1_advance;
  assign cfg_ready  = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_word_address = addr_r;
  assign out_word_valid   = wvalid_r;
  assign out_last_word    = last_r;
  assign out_busy_res     = clear_active_r;

  assign off_inc = word_offset_r + 16'd1;
  assign rem_dec = words_remaining_r - 14'd1;
  assign pos_inc = run_position_r + 6'd1;

  always_comb begin
    bank_base_nxt       = bank_base_r;
    word_offset_nxt     = word_offset_r;
    words_remaining_nxt = words_remaining_r;
    run_position_nxt    = run_position_r;
    clear_active_nxt    = clear_active_r;
    addr_nxt            = '0;
    wvalid_nxt          = 1'b0;
    last_nxt            = 1'b0;
    if (dlcag_pkg::action_t'(s1_action_r) == dlcag_pkg::ACT_START) begin
      bank_base_nxt       = s1_bank_r;
      word_offset_nxt     = {s1_start_r, 6'd0} + {11'd0, initial_skip_r};
      words_remaining_nxt = (dlcag_pkg::ListBaseWords << s1_size_r)
                            - {9'd0, initial_skip_r};
      run_position_nxt    = '0;
      clear_active_nxt    = (clear_run_r != '0) && (words_remaining_nxt != '0);
    end else if (clear_active_r) begin
      addr_nxt            = {bank_base_r, word_offset_r} & AddrMask;
      wvalid_nxt          = 1'b1;
      word_offset_nxt     = off_inc;
      words_remaining_nxt = rem_dec;
      run_position_nxt    = pos_inc;
      if (rem_dec == '0) begin
        clear_active_nxt = 1'b0;
      end else if (pos_inc >= clear_run_r) begin
        run_position_nxt = '0;
        if (rem_dec <= {9'd0, skip_run_r}) begin
          words_remaining_nxt = '0;
          clear_active_nxt    = 1'b0;
        end else begin
          words_remaining_nxt = rem_dec - {9'd0, skip_run_r};
          word_offset_nxt     = off_inc + {11'd0, skip_run_r};
        end
      end
      last_nxt = !clear_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_skip_r <= '0;
      skip_run_r     <= '0;
      clear_run_r    <= '0;
    end else if (cfg_valid) begin
      case (dlcag_pkg::cfg_idx_t'(cfg_index))
        dlcag_pkg::CFG_INITIAL_SKIP: initial_skip_r <= cfg_data[dlcag_pkg::SkipW-1:0];
        dlcag_pkg::CFG_SKIP_RUN:     skip_run_r     <= cfg_data[dlcag_pkg::SkipW-1:0];
        dlcag_pkg::CFG_CLEAR_RUN:    clear_run_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && in_valid) begin
      s1_action_r <= in_action;
      s1_bank_r   <= in_list_bank;
      s1_start_r  <= in_list_start;
      s1_size_r   <= in_size_select;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_base_r       <= '0;
      word_offset_r     <= '0;
      words_remaining_r <= '0;
      run_position_r    <= '0;
      clear_active_r    <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (s2_advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        bank_base_r       <= bank_base_nxt;
        word_offset_r     <= word_offset_nxt;
        words_remaining_r <= words_remaining_nxt;
        run_position_r    <= run_position_nxt;
        clear_active_r    <= clear_active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      addr_r   <= addr_nxt;
      wvalid_r <= wvalid_nxt;
      last_r   <= last_nxt;
    end
  end

endmodule
`default_nettype wire

[verif/display_list_clear_address_gen_chk.sv]
// Checker for the display-list clear address generator: watches the config, item and
// result channels, predicts each result and compares it field by field.
// Depends on dlcag_pkg.
`timescale 1ns / 100ps
module display_list_clear_address_gen_chk #(
  parameter int unsigned MEMORY_WORDS = dlcag_pkg::MemoryWordsDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic                          in_action,
  input  wire logic [dlcag_pkg::BankW-1:0]   in_list_bank,
  input  wire logic [dlcag_pkg::StartW-1:0]  in_list_start,
  input  wire logic [dlcag_pkg::SizeW-1:0]   in_size_select,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [dlcag_pkg::AddrW-1:0]   out_word_address,
  input  wire logic                          out_word_valid,
  input  wire logic                          out_last_word,
  input  wire logic                          out_busy_res,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [dlcag_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [dlcag_pkg::CfgDatW-1:0] cfg_data,
  output int                                 error_count,
  output int                                 pending_count,
  output int                                 words_cleared,
  output int                                 clears_finished
);

  localparam logic [dlcag_pkg::AddrW-1:0] AddrMask = dlcag_pkg::AddrW'(MEMORY_WORDS - 1);

  typedef struct packed {
    logic [dlcag_pkg::AddrW-1:0] word_address;
    logic                        word_valid;
    logic                        last_word;
    logic                        busy;
  } clear_word_t;

  clear_word_t expected_words[$];

  logic [dlcag_pkg::SkipW-1:0]   initial_skip_r;
  logic [dlcag_pkg::SkipW-1:0]   skip_run_r;
  logic [dlcag_pkg::RunW-1:0]    clear_run_r;
  logic [dlcag_pkg::BankW-1:0]   bank_r;
  logic [dlcag_pkg::OffsetW-1:0] offset_r;
  logic [dlcag_pkg::RemainW-1:0] remaining_r;
  logic [dlcag_pkg::RunW-1:0]    run_pos_r;
  logic                          active_r;

  always @(posedge clk) begin
    clear_word_t want;
    if (!rst_n) begin
      initial_skip_r = '0;
      skip_run_r = '0;
      clear_run_r = '0;
      bank_r = '0;
      offset_r = '0;
      remaining_r = '0;
      run_pos_r = '0;
      active_r = 1'b0;
      expected_words.delete();
      error_count = 0;
      words_cleared = 0;
      clears_finished = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (dlcag_pkg::cfg_idx_t'(cfg_index))
          dlcag_pkg::CFG_INITIAL_SKIP: initial_skip_r = cfg_data[dlcag_pkg::SkipW-1:0];
          dlcag_pkg::CFG_SKIP_RUN:     skip_run_r = cfg_data[dlcag_pkg::SkipW-1:0];
          dlcag_pkg::CFG_CLEAR_RUN:    clear_run_r = cfg_data[dlcag_pkg::RunW-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result with no item pending: word_address %0h", out_word_address);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_word_address !== want.word_address) begin
            $error("word_address expected %0h got %0h", want.word_address, out_word_address);
            error_count++;
          end
          if (out_word_valid !== want.word_valid) begin
            $error("word_valid expected %0b got %0b", want.word_valid, out_word_valid);
            error_count++;
          end
          if (out_last_word !== want.last_word) begin
            $error("last_word expected %0b got %0b", want.last_word, out_last_word);
            error_count++;
          end
          if (out_busy_res !== want.busy) begin
            $error("busy_res expected %0b got %0b", want.busy, out_busy_res);
            error_count++;
          end
          if (want.word_valid) words_cleared++;
          if (want.last_word) clears_finished++;
        end
      end

      if (in_valid && in_ready) begin
        want = '0;
        if (dlcag_pkg::action_t'(in_action) == dlcag_pkg::ACT_START) begin
          bank_r = in_list_bank;
          offset_r = {in_list_start, 6'b0} + dlcag_pkg::OffsetW'(initial_skip_r);
          remaining_r = (dlcag_pkg::ListBaseWords << in_size_select)
                        - dlcag_pkg::RemainW'(initial_skip_r);
          run_pos_r = '0;
          active_r = (clear_run_r != 0) && (remaining_r != 0);
        end else if (active_r) begin
          want.word_address = {bank_r, offset_r} & AddrMask;
          want.word_valid = 1'b1;
          offset_r = offset_r + 1'b1;
          remaining_r = remaining_r - 1'b1;
          run_pos_r = run_pos_r + 1'b1;
          if (remaining_r == 0) begin
            active_r = 1'b0;
          end else if (run_pos_r >= clear_run_r) begin
            run_pos_r = '0;
            if (remaining_r <= dlcag_pkg::RemainW'(skip_run_r)) begin
              remaining_r = '0;
              active_r = 1'b0;
            end else begin
              remaining_r = remaining_r - dlcag_pkg::RemainW'(skip_run_r);
              offset_r = offset_r + dlcag_pkg::OffsetW'(skip_run_r);
            end
          end
          want.last_word = !active_r;
        end
        want.busy = active_r;
        expected_words.push_back(want);
      end
    end
    pending_count <= expected_words.size();
  end

endmodule

[verif/display_list_clear_address_gen_tb.sv]
// Testbench top for the display-list clear address generator: drives config writes,
// start and next items under several idle patterns, and reports the verdict.
// Depends on dlcag_pkg, display_list_clear_address_gen and its checker.
`timescale 1ns / 100ps
module display_list_clear_address_gen_tb;

  localparam int CycleLimit = 400000;
  localparam int PhaseCount = 12;
  localparam int PhaseItems = 95;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_action;
  logic [dlcag_pkg::BankW-1:0]   in_list_bank;
  logic [dlcag_pkg::StartW-1:0]  in_list_start;
  logic [dlcag_pkg::SizeW-1:0]   in_size_select;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [dlcag_pkg::AddrW-1:0]   out_word_address;
  logic                          out_word_valid;
  logic                          out_last_word;
  logic                          out_busy_res;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [dlcag_pkg::CfgIdxW-1:0] cfg_index;
  logic [dlcag_pkg::CfgDatW-1:0] cfg_data;

  int error_count;
  int pending_count;
  int words_cleared;
  int clears_finished;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;

  display_list_clear_address_gen uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_list_bank(in_list_bank), .in_list_start(in_list_start),
    .in_size_select(in_size_select),
    .out_valid(out_valid), .out_ready(out_ready), .out_word_address(out_word_address),
    .out_word_valid(out_word_valid), .out_last_word(out_last_word),
    .out_busy_res(out_busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  display_list_clear_address_gen_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_list_bank(in_list_bank), .in_list_start(in_list_start),
    .in_size_select(in_size_select),
    .out_valid(out_valid), .out_ready(out_ready), .out_word_address(out_word_address),
    .out_word_valid(out_word_valid), .out_last_word(out_last_word),
    .out_busy_res(out_busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .pending_count(pending_count),
    .words_cleared(words_cleared), .clears_finished(clears_finished)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("display_list_clear_address_gen_tb: done, errors");
      $finish;
    end
  end

  task automatic push_item(input dlcag_pkg::action_t act,
                           input logic [dlcag_pkg::BankW-1:0] bank,
                           input logic [dlcag_pkg::StartW-1:0] start,
                           input logic [dlcag_pkg::SizeW-1:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_list_bank <= bank;
    in_list_start <= start;
    in_size_select <= size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic push_next();
    push_item(dlcag_pkg::ACT_NEXT, dlcag_pkg::BankW'($urandom),
              dlcag_pkg::StartW'($urandom), dlcag_pkg::SizeW'($urandom));
  endtask

  task automatic push_random_start();
    logic [dlcag_pkg::StartW-1:0] start;
    logic [dlcag_pkg::SizeW-1:0]  size;
    start = ($urandom_range(9) == 0) ? dlcag_pkg::StartW'($urandom_range(1023, 1020))
                                     : dlcag_pkg::StartW'($urandom_range(1023));
    size = ($urandom_range(9) < 7) ? 2'd0 : dlcag_pkg::SizeW'($urandom_range(3));
    push_item(dlcag_pkg::ACT_START, dlcag_pkg::BankW'($urandom_range(15)), start, size);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_reg(input dlcag_pkg::cfg_idx_t idx,
                           input logic [dlcag_pkg::CfgDatW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_settings(input logic [dlcag_pkg::CfgDatW-1:0] init_skip,
                                input logic [dlcag_pkg::CfgDatW-1:0] skip_run,
                                input logic [dlcag_pkg::CfgDatW-1:0] clear_run);
    write_reg(dlcag_pkg::CFG_INITIAL_SKIP, init_skip);
    write_reg(dlcag_pkg::CFG_SKIP_RUN, skip_run);
    write_reg(dlcag_pkg::CFG_CLEAR_RUN, clear_run);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int budget;
    int nexts;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = dlcag_pkg::ACT_START;
    in_list_bank = '0;
    in_list_start = '0;
    in_size_select = '0;
    cfg_valid = 1'b0;
    cfg_index = dlcag_pkg::CFG_INITIAL_SKIP;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero clear run after reset: start stays idle, next returns zeros
    push_item(dlcag_pkg::ACT_START, 4'hF, 10'h3FF, 2'd3);
    push_item(dlcag_pkg::ACT_NEXT, 4'h0, 10'h000, 2'd0);
    drain();
    write_settings(6'd31, 6'd31, 6'd1);
    push_item(dlcag_pkg::ACT_START, 4'h0, 10'h000, 2'd0);
    repeat (3) push_item(dlcag_pkg::ACT_NEXT, 4'hF, 10'h3FF, 2'd3);
    // restart while busy, near the top of the bank so the offset wraps
    push_item(dlcag_pkg::ACT_START, 4'hF, 10'h3FF, 2'd3);
    repeat (5) push_next();
    drain();
    write_settings(6'd0, 6'd0, 6'd63);
    push_item(dlcag_pkg::ACT_START, 4'h9, 10'h3FF, 2'd1);
    repeat (7) push_next();
    drain();
    // lower the run length below the current position mid-clear
    write_settings(6'd0, 6'd0, 6'd2);
    repeat (3) push_next();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain();
      case (phase % 6)
        0: write_settings(6'd0, 6'd0, 6'd1);
        1: write_settings(6'd31, 6'd31, 6'd1);
        2: write_settings(6'($urandom_range(63)), 6'd31, 6'($urandom_range(4, 1)));
        3: write_settings(6'($urandom_range(63)), 6'($urandom_range(63)), 6'd63);
        4: write_settings(6'($urandom_range(63)), 6'($urandom_range(63)), 6'd0);
        default: write_settings(6'($urandom), 6'($urandom), 6'($urandom));
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      budget = PhaseItems;
      if ($urandom_range(1) == 0) begin
        nexts = $urandom_range(30, 5);
        repeat (nexts) push_next();
        budget -= nexts;
      end
      while (budget > 0) begin
        if ($urandom_range(11) == 0) begin
          push_next();
          budget--;
        end else begin
          push_random_start();
          budget--;
          nexts = $urandom_range(110, 5);
          if (nexts > budget) nexts = budget;
          for (int n = 0; n < nexts; n++) begin
            if ($urandom_range(24) == 0) push_random_start();
            else push_next();
            budget--;
          end
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d items over %0d register settings and four idle patterns;",
             items_sent, PhaseCount + 4);
    $display("%0d word addresses checked, %0d clears ran to their last word.",
             words_cleared, clears_finished);
    if (error_count == 0) begin
      $display("display_list_clear_address_gen_tb: done, clean");
    end else begin
      $display("display_list_clear_address_gen_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/dlcag_pkg.sv
hdl/display_list_clear_address_gen.sv
verif/display_list_clear_address_gen_chk.sv
verif/display_list_clear_address_gen_tb.sv
